// ----- rtl/hed_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex escape decoder package
// Shared characters, escape phase codes, the per-byte decode record and the
// hex digit helpers.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] XChar         = 8'h78;
  localparam int unsigned MaxResults   = 3;
  localparam int unsigned CntW         = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhBs    = 2'd1,
    PhX     = 2'd2,
    PhDigit = 2'd3
  } phase_e;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CntW-1:0]            count;
    logic                       last_item;
  } group_t;

  typedef struct packed {
    group_t     grp;
    phase_e     phase_n;
    logic [7:0] first_n;
  } dec_t;

  // Returns {valid, value}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
    logic [4:0] a;
    logic [4:0] b;
    logic [7:0] r;
    a = hex_value(hi);
    b = hex_value(lo);
    if (!a[4]) begin
      r = 8'd0;
    end else if (!b[4]) begin
      r = {4'd0, a[3:0]};
    end else begin
      r = {a[3:0], b[3:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/hed_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex escape decoder step logic
// Works out the next escape phase and the group of zero to three bytes that
// one input byte releases, including the flush at stream end.
// ----------------------------------------------------------------------------
module hed_decode import hed_pkg::*; (
  input  phase_e     phase_i,
  input  logic [7:0] first_i,
  input  logic [7:0] byte_i,
  input  logic       end_i,
  output dec_t       dec_o
);

  phase_e     ph_n;
  logic [7:0] first_n;
  logic [7:0] m0;
  logic [7:0] m1;
  logic [1:0] mcnt;
  logic [1:0] fcnt;
  logic [2:0] total;

  always_comb begin
    ph_n    = PhIdle;
    first_n = first_i;
    m0      = byte_i;
    m1      = byte_i;
    mcnt    = 2'd0;
    unique case (phase_i)
      PhIdle: begin
        if (byte_i == BackslashChar) begin
          ph_n = PhBs;
        end else begin
          mcnt = 2'd1;
        end
      end
      PhBs: begin
        if (byte_i == XChar) begin
          ph_n = PhX;
        end else begin
          m0 = BackslashChar;
          if (byte_i == BackslashChar) begin
            ph_n = PhBs;
            mcnt = 2'd1;
          end else begin
            mcnt = 2'd2;
          end
        end
      end
      PhX: begin
        first_n = byte_i;
        ph_n    = PhDigit;
      end
      PhDigit: begin
        m0   = decode_pair(first_i, byte_i);
        mcnt = 2'd1;
      end
      default: ph_n = PhIdle;
    endcase
  end

  assign fcnt  = end_i ? 2'(ph_n) : 2'd0;
  assign total = {1'b0, mcnt} + {1'b0, fcnt};

  always_comb begin
    dec_o.grp.count     = total[CntW-1:0];
    dec_o.grp.last_item = end_i;
    dec_o.phase_n       = end_i ? PhIdle : ph_n;
    dec_o.first_n       = first_n;
    case (mcnt)
      2'd2: begin
        dec_o.grp.bytes[0] = m0;
        dec_o.grp.bytes[1] = m1;
        dec_o.grp.bytes[2] = BackslashChar;
      end
      2'd1: begin
        dec_o.grp.bytes[0] = m0;
        dec_o.grp.bytes[1] = BackslashChar;
        dec_o.grp.bytes[2] = XChar;
      end
      default: begin
        dec_o.grp.bytes[0] = BackslashChar;
        dec_o.grp.bytes[1] = XChar;
        dec_o.grp.bytes[2] = first_n;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/hed_out_buf.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex escape decoder result buffer
// Holds one group of decoded bytes and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module hed_out_buf import hed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  group_t     grp_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       end_seen_o
);

  logic [MaxResults-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       end_q, end_d;
  logic                       take;

  assign take        = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = bytes_q[0];
  assign run_last_o  = (cnt_q == CntW'(1));
  assign end_seen_o  = run_last_o && end_q;
  assign room_o      = (cnt_q == '0) || (run_last_o && out_ready_i);

  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    end_d   = end_q;
    if (load_i) begin
      bytes_d = grp_i.bytes;
      cnt_d   = grp_i.count;
      end_d   = grp_i.last_item;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      end_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      end_q <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

endmodule
`default_nettype wire

// ----- rtl/hex_escape_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hex escape decoder
// Replaces backslash, 'x', digit, digit sequences in a byte stream with the
// byte they encode and passes every other byte through.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one raw byte per transfer together with a
//   stream end flag. The output channel gives decoded bytes, with run_last
//   on the last byte caused by an input and end_seen on the final byte of
//   a stream end input. An input may cause no output byte at all.
//   The escape phase is decoded in the same cycle as the transfer, and the
//   resulting group of up to three bytes is registered, so the first byte
//   appears in the cycle after its input transfer.
//   A new byte is accepted in every cycle while each input releases at most
//   one byte and the receiver is ready; an input that releases two or three
//   bytes (a broken escape or a stream end flush) holds the input until the
//   result buffer is handing out the last of them.
//   Reset clears the escape phase and empties the result buffer. When the
//   receiver stalls, the buffered bytes hold and the input is held off once
//   the buffer has no room for another group.
// ----------------------------------------------------------------------------
module hex_escape_decoder import hed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       stream_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       end_seen_o
);

  phase_e     phase_q;
  logic [7:0] first_q;
  dec_t       dec;
  logic       accept;

  assign accept = in_valid_i && in_ready_o;

  hed_decode u_decode (
    .phase_i (phase_q),
    .first_i (first_q),
    .byte_i  (in_byte_i),
    .end_i   (stream_end_i),
    .dec_o   (dec)
  );

  hed_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .grp_i       (dec.grp),
    .room_o      (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .end_seen_o  (end_seen_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      first_q <= 8'd0;
    end else if (accept) begin
      phase_q <= dec.phase_n;
      first_q <= dec.first_n;
    end
  end

  a_end_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stream_end_i |=> phase_q == PhIdle)
    else $error("Escape phase not cleared after stream end.");

  a_end_gives_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stream_end_i |=> out_valid_o)
    else $error("Stream end transfer released no byte.");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_seen_o |-> run_last_o && out_valid_o)
    else $error("End flag shown on a byte that is not the last of its group.");

  a_valid_follows_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o == ($past(dec.grp.count) != '0))
    else $error("Output valid does not match the loaded group size.");

endmodule
`default_nettype wire
